// ===== rtl/core/rpc_pkg.sv =====
package rpc_pkg;

  localparam int ENTRIES    = 32;
  localparam int TIME_WIDTH = 32;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLOT_W     = 5;
  localparam int ADDR_W     = 64;
  localparam int FLAG_W     = 32;
  localparam int CFG_DW     = 32;
  localparam int CFG_AW     = 4;
  localparam int AGE_W      = (TIME_WIDTH > CFG_DW) ? TIME_WIDTH : CFG_DW;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [CFG_DW-1:0] EXPIRY_RST = 32'd5000;
  localparam logic [CFG_DW-1:0] RMASK_RST  = 32'd238;
  localparam logic [CFG_DW-1:0] WMASK_RST  = 32'd204;
  localparam logic [CFG_DW-1:0] DMASK_RST  = 32'd257;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_FILL   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_REJECT   = 3'd0,
    ST_HIT_OK   = 3'd1,
    ST_HIT_DENY = 3'd2,
    ST_MISS     = 3'd3,
    ST_FILLED   = 3'd4,
    ST_DONE     = 3'd5
  } res_status_t;

  typedef enum logic [1:0] {
    REG_EXPIRY = 2'd0,
    REG_RMASK  = 2'd1,
    REG_WMASK  = 2'd2,
    REG_DMASK  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOOK,
    S_FSCAN,
    S_FWR,
    S_OUT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_PROC,
    SLOT_PICK
  } slot_sel_t;

  typedef struct packed {
    logic [CFG_DW-1:0] expiry;
    logic [CFG_DW-1:0] rmask;
    logic [CFG_DW-1:0] wmask;
    logic [CFG_DW-1:0] dmask;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic              access_kind;
    logic [ADDR_W-1:0] query_address;
    logic [ADDR_W-1:0] query_length;
    logic [ADDR_W-1:0] region_base;
    logic [ADDR_W-1:0] region_length;
    logic [FLAG_W-1:0] region_flags;
  } req_pay_t;

  typedef struct packed {
    logic        capture;
    logic        tick;
    logic        clear;
    logic        scan_start;
    logic        scan_stop;
    logic        look_proc;
    logic        fill_proc;
    logic        hit_take;
    logic        fill_write;
    logic        res_load;
    res_status_t res_status;
    slot_sel_t   slot_sel;
    logic        post;
  } cmd_t;

  typedef struct packed {
    req_kind_t req;
    logic      reject;
    logic      hit;
    logic      allow;
    logic      proc_last;
    logic      out_free;
  } stat_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    return SLOT_W'(idx);
  endfunction

endpackage

// ===== rtl/core/rpc_if.sv =====
interface rpc_req_if import rpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic              access_kind;
  logic [ADDR_W-1:0] query_address;
  logic [ADDR_W-1:0] query_length;
  logic [ADDR_W-1:0] region_base;
  logic [ADDR_W-1:0] region_length;
  logic [FLAG_W-1:0] region_flags;

  modport source (
    output valid, req_type, access_kind, query_address, query_length,
           region_base, region_length, region_flags,
    input  ready
  );
  modport sink (
    input  valid, req_type, access_kind, query_address, query_length,
           region_base, region_length, region_flags,
    output ready
  );
endinterface

interface rpc_rsp_if import rpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, status, slot, input ready);
  modport sink (input valid, status, slot, output ready);
endinterface

// ===== rtl/core/region_permission_cache_top.sv =====
// Region permission cache: a fully associative table of memory regions that
// answers read/write permission checks on address ranges.
// in_chan (valid/ready) carries one request: tick, lookup, fill or clear.
// out_chan (valid/ready) returns exactly one result per request: status and
// slot. The APB port (psel/penable/pwrite/paddr/pwdata) sets expiry and the
// permission masks; pready is tied high and writes take effect on the
// access cycle. Configure only while no request is in flight.
// Tick, clear and rejected lookups go from the check state straight to the
// output state. Lookups and fills walk the entry store one entry per
// cycle through its single read port: a lookup stops at the first hit,
// a fill always scans every entry and then writes the chosen one.
// One request is in work at a time; in_chan.ready is high in the idle
// state only, so no new request is taken before the last result is loaded.
// A result sits in an output register; a new request is taken while it
// waits, and the next result holds inside until the register empties.
// Reset (rst_n low, synchronous) empties the table, zeroes the tick
// counter and restores the register defaults; no clearing pass follows.
module region_permission_cache_top import rpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rpc_req_if.sink           in_chan,
  rpc_rsp_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  cmd_t     cmd;
  stat_t    st;
  req_pay_t in_pay;
  logic     in_ready;

  assign in_pay.req_type      = in_chan.req_type;
  assign in_pay.access_kind   = in_chan.access_kind;
  assign in_pay.query_address = in_chan.query_address;
  assign in_pay.query_length  = in_chan.query_length;
  assign in_pay.region_base   = in_chan.region_base;
  assign in_pay.region_length = in_chan.region_length;
  assign in_pay.region_flags  = in_chan.region_flags;
  assign in_chan.ready        = in_ready;

  rpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rpc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pay     (in_pay),
    .cfg        (cfg),
    .cmd        (cmd),
    .out_ready  (out_chan.ready),
    .st         (st),
    .out_vld    (out_chan.valid),
    .out_status (out_chan.status),
    .out_slot   (out_chan.slot)
  );

endmodule

// ===== rtl/core/rpc_cfg.sv =====
module rpc_cfg import rpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [CFG_DW-1:0] expiry_r, rmask_r, wmask_r, dmask_r;
  logic              wr_en;
  cfg_reg_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = cfg_reg_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= EXPIRY_RST;
      rmask_r  <= RMASK_RST;
      wmask_r  <= WMASK_RST;
      dmask_r  <= DMASK_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_EXPIRY: expiry_r <= pwdata;
        REG_RMASK:  rmask_r  <= pwdata;
        REG_WMASK:  wmask_r  <= pwdata;
        REG_DMASK:  dmask_r  <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_EXPIRY: prdata = expiry_r;
      REG_RMASK:  prdata = rmask_r;
      REG_WMASK:  prdata = wmask_r;
      REG_DMASK:  prdata = dmask_r;
      default:    prdata = '0;
    endcase
  end

  assign cfg.expiry = expiry_r;
  assign cfg.rmask  = rmask_r;
  assign cfg.wmask  = wmask_r;
  assign cfg.dmask  = dmask_r;

endmodule

// ===== rtl/core/rpc_dp.sv =====
module rpc_dp import rpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  req_pay_t          in_pay,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  input  logic              out_ready,
  output stat_t             st,
  output logic              out_vld,
  output logic [2:0]        out_status,
  output logic [SLOT_W-1:0] out_slot
);

  // captured request
  req_kind_t         req_type_r;
  logic              kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic              len_zero_r;
  logic [ADDR_W:0]   qend_r;
  logic [ADDR_W-1:0] fbase_r;
  logic [ADDR_W:0]   fend_r;
  logic [FLAG_W-1:0] fflags_r;

  logic [TIME_WIDTH-1:0] time_now_r;
  logic [ENTRIES-1:0]    valid_r;

  // entry store; end is base + length kept as a 65-bit sum
  logic [ADDR_W-1:0]     base_mem  [ENTRIES];
  logic [ADDR_W:0]       end_mem   [ENTRIES];
  logic [FLAG_W-1:0]     flags_mem [ENTRIES];
  logic [TIME_WIDTH-1:0] stamp_mem [ENTRIES];

  logic [ADDR_W-1:0]     base_q;
  logic [ADDR_W:0]       end_q;
  logic [FLAG_W-1:0]     flags_q;
  logic [TIME_WIDTH-1:0] stamp_q;

  logic             issue_r, proc_vld_r;
  logic [IDX_W-1:0] rd_idx_r, proc_idx_r;

  logic                  free_found_r;
  logic [IDX_W-1:0]      free_idx_r, best_idx_r;
  logic [TIME_WIDTH-1:0] best_age_r;

  res_status_t       res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              out_vld_r;
  res_status_t       out_status_r;
  logic [SLOT_W-1:0] out_slot_r;

  logic [TIME_WIDTH-1:0] age;
  logic                  expired, covers, cur_valid;
  logic [CFG_DW-1:0]     allow_mask;
  logic [IDX_W-1:0]      pick, stamp_waddr;
  logic                  stamp_we;
  logic [SLOT_W-1:0]     slot_val;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r <= req_kind_t'(in_pay.req_type);
      kind_r     <= in_pay.access_kind;
      addr_r     <= in_pay.query_address;
      len_zero_r <= (in_pay.query_length == '0);
      qend_r     <= {1'b0, in_pay.query_address} + {1'b0, in_pay.query_length};
      fbase_r    <= in_pay.region_base;
      fend_r     <= {1'b0, in_pay.region_base} + {1'b0, in_pay.region_length};
      fflags_r   <= in_pay.region_flags;
    end
  end

  assign age        = TIME_WIDTH'(time_now_r - stamp_q);
  assign expired    = AGE_W'(age) > AGE_W'(cfg.expiry);
  assign covers     = (addr_r >= base_q) && (qend_r <= end_q);
  assign cur_valid  = valid_r[proc_idx_r];
  assign allow_mask = kind_r ? cfg.wmask : cfg.rmask;
  assign pick       = free_found_r ? free_idx_r : best_idx_r;

  assign st.req       = req_type_r;
  assign st.reject    = (addr_r == '0) || len_zero_r || qend_r[ADDR_W];
  assign st.hit       = proc_vld_r && cur_valid && !expired && covers;
  assign st.allow     = (|(flags_q & allow_mask)) && !(|(flags_q & cfg.dmask));
  assign st.proc_last = proc_vld_r && (proc_idx_r == LAST_IDX);
  assign st.out_free  = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r <= '0;
    end else if (cmd.tick) begin
      time_now_r <= time_now_r + TIME_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
    end else begin
      // entries passed on a lookup scan drop out once they age past the limit
      if (cmd.look_proc && proc_vld_r && cur_valid && expired) begin
        valid_r[proc_idx_r] <= 1'b0;
      end
      if (cmd.fill_write) begin
        valid_r[pick] <= 1'b1;
      end
    end
  end

  // scan engine: one read issued per cycle, processed the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r    <= 1'b0;
      proc_vld_r <= 1'b0;
      rd_idx_r   <= '0;
      proc_idx_r <= '0;
    end else if (cmd.scan_start) begin
      issue_r    <= 1'b1;
      proc_vld_r <= 1'b0;
      rd_idx_r   <= '0;
    end else if (cmd.scan_stop) begin
      issue_r    <= 1'b0;
      proc_vld_r <= 1'b0;
    end else begin
      proc_vld_r <= issue_r;
      if (issue_r) begin
        proc_idx_r <= rd_idx_r;
        if (rd_idx_r == LAST_IDX) begin
          issue_r <= 1'b0;
        end else begin
          rd_idx_r <= rd_idx_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    base_q  <= base_mem[rd_idx_r];
    end_q   <= end_mem[rd_idx_r];
    flags_q <= flags_mem[rd_idx_r];
    stamp_q <= stamp_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_write) begin
      base_mem[pick]  <= fbase_r;
      end_mem[pick]   <= fend_r;
      flags_mem[pick] <= fflags_r;
    end
  end

  assign stamp_we    = cmd.hit_take || cmd.fill_write;
  assign stamp_waddr = cmd.hit_take ? proc_idx_r : pick;

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= time_now_r;
    end
  end

  // fill victim: lowest free entry, else largest age (lowest index on a tie)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_found_r <= 1'b0;
    end else if (cmd.scan_start) begin
      free_found_r <= 1'b0;
    end else if (cmd.fill_proc && proc_vld_r && !cur_valid && !free_found_r) begin
      free_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_proc && proc_vld_r) begin
      if (!cur_valid && !free_found_r) begin
        free_idx_r <= proc_idx_r;
      end
      if ((proc_idx_r == '0) || (age > best_age_r)) begin
        best_age_r <= age;
        best_idx_r <= proc_idx_r;
      end
    end
  end

  always_comb begin
    case (cmd.slot_sel)
      SLOT_PROC: slot_val = slot_of(proc_idx_r);
      SLOT_PICK: slot_val = slot_of(pick);
      default:   slot_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_slot_r   <= slot_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.post) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_vld    = out_vld_r;
  assign out_status = 3'(out_status_r);
  assign out_slot   = out_slot_r;

endmodule

// ===== rtl/core/rpc_ctrl.sv =====
module rpc_ctrl import rpc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (st.req)
          REQ_TICK: begin
            cmd.tick       = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_DONE;
            cmd.slot_sel   = SLOT_ZERO;
            state_nxt      = S_OUT;
          end
          REQ_CLEAR: begin
            cmd.clear      = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_DONE;
            cmd.slot_sel   = SLOT_ZERO;
            state_nxt      = S_OUT;
          end
          REQ_LOOKUP: begin
            if (st.reject) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_REJECT;
              cmd.slot_sel   = SLOT_ZERO;
              state_nxt      = S_OUT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_LOOK;
            end
          end
          REQ_FILL: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_FSCAN;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_LOOK: begin
        cmd.look_proc = 1'b1;
        if (st.hit) begin
          cmd.hit_take   = 1'b1;
          cmd.scan_stop  = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = st.allow ? ST_HIT_OK : ST_HIT_DENY;
          cmd.slot_sel   = SLOT_PROC;
          state_nxt      = S_OUT;
        end else if (st.proc_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_MISS;
          cmd.slot_sel   = SLOT_ZERO;
          state_nxt      = S_OUT;
        end
      end
      S_FSCAN: begin
        cmd.fill_proc = 1'b1;
        if (st.proc_last) begin
          state_nxt = S_FWR;
        end
      end
      S_FWR: begin
        cmd.fill_write = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_FILLED;
        cmd.slot_sel   = SLOT_PICK;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register frees up
        if (st.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import rpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 1_000_000;

  typedef struct packed {
    res_status_t       status;
    logic [SLOT_W-1:0] slot;
  } verdict_t;

  typedef enum logic [1:0] {
    SEND_LIGHT,   // sender idles 11%, receiver 51%
    RECV_LIGHT,   // sender idles 51%, receiver 11%
    NO_IDLE
  } idle_mode_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  rpc_req_if in_chan();
  rpc_rsp_if out_chan();

  region_permission_cache_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // predictor copy of the region table and registers
  logic [ADDR_W-1:0]     rgn_base  [ENTRIES];
  logic [ADDR_W-1:0]     rgn_len   [ENTRIES];
  logic [FLAG_W-1:0]     rgn_prot  [ENTRIES];
  logic [TIME_WIDTH-1:0] rgn_stamp [ENTRIES];
  logic                  rgn_live  [ENTRIES];
  logic [TIME_WIDTH-1:0] tick_count;
  logic [CFG_DW-1:0]     cfg_expiry;
  logic [CFG_DW-1:0]     cfg_rmask;
  logic [CFG_DW-1:0]     cfg_wmask;
  logic [CFG_DW-1:0]     cfg_dmask;

  req_pay_t          req_backlog [$];
  verdict_t          answers_due [$];
  logic [ADDR_W-1:0] seen_base   [$];
  logic [ADDR_W-1:0] seen_len    [$];

  req_pay_t   cur_req;
  verdict_t   got_want;
  idle_mode_t idle_mode;
  int         mismatches;
  int         cycle_cnt;

  function automatic verdict_t cache_answer(input req_pay_t r);
    verdict_t              v;
    int                    i;
    int                    pick;
    logic                  found;
    logic [TIME_WIDTH-1:0] age;
    logic [TIME_WIDTH-1:0] best;
    logic [FLAG_W-1:0]     allow;
    logic [ADDR_W:0]       qend;
    v.status = ST_DONE;
    v.slot   = '0;
    case (r.req_type)
      REQ_TICK: tick_count = tick_count + 1'b1;
      REQ_LOOKUP: begin
        qend = {1'b0, r.query_address} + {1'b0, r.query_length};
        if (r.query_address == '0 || r.query_length == '0 || qend[ADDR_W]) begin
          v.status = ST_REJECT;
        end else begin
          v.status = ST_MISS;
          found = 1'b0;
          for (i = 0; i < ENTRIES && !found; i++) begin
            age = tick_count - rgn_stamp[i];
            if (!rgn_live[i]) begin
              // skip
            end else if (age > cfg_expiry) begin
              rgn_live[i] = 1'b0;
            end else if (r.query_address >= rgn_base[i] &&
                         qend <= {1'b0, rgn_base[i]} + {1'b0, rgn_len[i]}) begin
              found        = 1'b1;
              rgn_stamp[i] = tick_count;
              allow        = r.access_kind ? cfg_wmask : cfg_rmask;
              v.status     = ((rgn_prot[i] & allow) != '0 && (rgn_prot[i] & cfg_dmask) == '0)
                             ? ST_HIT_OK : ST_HIT_DENY;
              v.slot       = SLOT_W'(i);
            end
          end
        end
      end
      REQ_FILL: begin
        pick = -1;
        for (i = 0; i < ENTRIES; i++) begin
          if (!rgn_live[i] && pick < 0) pick = i;
        end
        if (pick < 0) begin
          // table full: evict the oldest, lowest index on a tie
          best = '0;
          pick = 0;
          for (i = 0; i < ENTRIES; i++) begin
            age = tick_count - rgn_stamp[i];
            if (i == 0 || age > best) begin
              best = age;
              pick = i;
            end
          end
        end
        rgn_base[pick]  = r.region_base;
        rgn_len[pick]   = r.region_length;
        rgn_prot[pick]  = r.region_flags;
        rgn_stamp[pick] = tick_count;
        rgn_live[pick]  = 1'b1;
        v.status        = ST_FILLED;
        v.slot          = SLOT_W'(pick);
      end
      default: begin
        for (i = 0; i < ENTRIES; i++) rgn_live[i] = 1'b0;
      end
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic send_gap();
    case (idle_mode)
      SEND_LIGHT: return $urandom_range(99, 0) < 11;
      RECV_LIGHT: return $urandom_range(99, 0) < 51;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic logic recv_stall();
    case (idle_mode)
      SEND_LIGHT: return $urandom_range(99, 0) < 51;
      RECV_LIGHT: return $urandom_range(99, 0) < 11;
      default:    return 1'b0;
    endcase
  endfunction

  // address/length go to both the query and the region fields
  task automatic push_req(input req_kind_t k, input logic ak, input logic [63:0] a,
                          input logic [63:0] l, input logic [31:0] f);
    req_pay_t r;
    r.req_type      = k;
    r.access_kind   = ak;
    r.query_address = a;
    r.query_length  = l;
    r.region_base   = a;
    r.region_length = l;
    r.region_flags  = f;
    req_backlog.push_back(r);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_EXPIRY: cfg_expiry = val;
      REG_RMASK:  cfg_rmask  = val;
      REG_WMASK:  cfg_wmask  = val;
      default:    cfg_dmask  = val;
    endcase
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (req_backlog.size() != 0 || in_chan.valid || answers_due.size() != 0)
      @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  task automatic gen_random(input int n);
    req_pay_t    r;
    int          pick;
    int          k;
    logic [63:0] b;
    logic [63:0] l;
    logic [63:0] off;
    repeat (n) begin
      r.access_kind   = $urandom_range(1, 0);
      r.query_address = rand64();
      r.query_length  = rand64();
      r.region_base   = rand64();
      r.region_length = rand64();
      r.region_flags  = $urandom;
      pick = $urandom_range(99, 0);
      if (pick < 20) begin
        r.req_type = REQ_TICK;
      end else if (pick < 21) begin
        r.req_type = REQ_CLEAR;
      end else if (pick < 48) begin
        r.req_type = REQ_FILL;
        if ($urandom_range(9, 0) != 0) begin
          b     = rand64();
          b[63] = 1'b0;
          if ($urandom_range(1, 0) == 0) b = b & 64'hFFFF_FFFF;
          r.region_base   = b;
          r.region_length = ($urandom_range(7, 0) == 0) ? 64'd0 : 64'($urandom_range(65536, 1));
        end
        if ($urandom_range(3, 0) != 0) r.region_flags = $urandom_range(511, 0);
        seen_base.push_back(r.region_base);
        seen_len.push_back(r.region_length);
        if (seen_base.size() > 48) begin
          void'(seen_base.pop_front());
          void'(seen_len.pop_front());
        end
      end else if (pick < 92) begin
        r.req_type = REQ_LOOKUP;
        if (seen_base.size() != 0 && $urandom_range(9, 0) < 8) begin
          k = $urandom_range(seen_base.size() - 1, 0);
          b = seen_base[k];
          l = seen_len[k];
          if (l == 0) begin
            r.query_address = b;
            r.query_length  = 64'($urandom_range(4, 1));
          end else begin
            off = rand64() % l;
            r.query_length = 1 + rand64() % (l - off);
            case ($urandom_range(7, 0))
              0: begin
                off            = '0;
                r.query_length = l;
              end
              1: r.query_length = r.query_length + 1;   // overrun by one byte
              2: off = off - 1;                         // may start before the base
              default: ;
            endcase
            r.query_address = b + off;
          end
        end else if ($urandom_range(1, 0) == 0) begin
          r.query_address = r.query_address & 64'hFFFF_FFFF;
          r.query_length  = 64'($urandom_range(70000, 1));
        end
      end else begin
        // malformed lookups: zero fields and ranges that run past the top
        r.req_type = REQ_LOOKUP;
        case ($urandom_range(2, 0))
          0: r.query_address = '0;
          1: r.query_length = '0;
          default: begin
            r.query_address = rand64() | 64'h8000_0000_0000_0000;
            r.query_length  = ~r.query_address + 64'($urandom_range(3, 1));
          end
        endcase
      end
      req_backlog.push_back(r);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // request driver; the expected answer is computed when a request is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        answers_due.push_back(cache_answer(cur_req));
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (req_backlog.size() != 0 && !send_gap()) begin
          cur_req = req_backlog.pop_front();
          in_chan.valid         <= 1'b1;
          in_chan.req_type      <= cur_req.req_type;
          in_chan.access_kind   <= cur_req.access_kind;
          in_chan.query_address <= cur_req.query_address;
          in_chan.query_length  <= cur_req.query_length;
          in_chan.region_base   <= cur_req.region_base;
          in_chan.region_length <= cur_req.region_length;
          in_chan.region_flags  <= cur_req.region_flags;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (answers_due.size() == 0) begin
          $error("unexpected result: status %0d slot %0d", out_chan.status, out_chan.slot);
          mismatches++;
        end else begin
          got_want = answers_due.pop_front();
          if (out_chan.status !== got_want.status) begin
            $error("status: expected %0d, got %0d", got_want.status, out_chan.status);
            mismatches++;
          end
          if (out_chan.slot !== got_want.slot) begin
            $error("slot: expected %0d, got %0d", got_want.slot, out_chan.slot);
            mismatches++;
          end
        end
      end
      out_chan.ready <= !recv_stall();
    end
  end

  initial begin
    rst_n                 = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_chan.valid         = 1'b0;
    in_chan.req_type      = '0;
    in_chan.access_kind   = 1'b0;
    in_chan.query_address = '0;
    in_chan.query_length  = '0;
    in_chan.region_base   = '0;
    in_chan.region_length = '0;
    in_chan.region_flags  = '0;
    out_chan.ready        = 1'b0;
    cycle_cnt             = 0;
    mismatches            = 0;
    tick_count            = '0;
    cfg_expiry            = EXPIRY_RST;
    cfg_rmask             = RMASK_RST;
    cfg_wmask             = WMASK_RST;
    cfg_dmask             = DMASK_RST;
    idle_mode             = SEND_LIGHT;
    for (int i = 0; i < ENTRIES; i++) rgn_live[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: rejects, boundaries, flag decisions, tick and clear
    push_req(REQ_LOOKUP, 1'b0, 64'd0, 64'd1, '0);
    push_req(REQ_LOOKUP, 1'b0, 64'd1, 64'd0, '0);
    push_req(REQ_LOOKUP, 1'b0, '1, 64'd1, '0);
    push_req(REQ_LOOKUP, 1'b0, 64'd1, '1, '0);
    push_req(REQ_LOOKUP, 1'b1, 64'd1, 64'hFFFF_FFFF_FFFF_FFFE, '0);
    push_req(REQ_FILL, 1'b0, 64'h1000, 64'h1000, 32'h2);
    push_req(REQ_LOOKUP, 1'b0, 64'h1000, 64'h1000, '0);
    push_req(REQ_LOOKUP, 1'b1, 64'h1000, 64'h1000, '0);
    push_req(REQ_LOOKUP, 1'b0, 64'h1800, 64'h801, '0);
    push_req(REQ_LOOKUP, 1'b0, 64'h1FFF, 64'd1, '0);
    push_req(REQ_FILL, 1'b0, 64'd0, 64'd0, 32'h0);
    push_req(REQ_FILL, 1'b0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, '1);
    push_req(REQ_LOOKUP, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 64'hF, '0);
    push_req(REQ_FILL, 1'b0, 64'h4000, 64'h100, 32'h104);
    push_req(REQ_LOOKUP, 1'b1, 64'h4000, 64'd1, '0);
    push_req(REQ_FILL, 1'b0, 64'h5000, 64'h10, 32'h4);
    push_req(REQ_LOOKUP, 1'b1, 64'h5000, 64'h10, '0);
    push_req(REQ_TICK, 1'b0, '1, '1, '1);
    push_req(REQ_TICK, 1'b1, '0, '0, '0);
    push_req(REQ_LOOKUP, 1'b0, 64'h0FFF, 64'd2, '0);
    push_req(REQ_CLEAR, 1'b1, '1, '1, '1);
    push_req(REQ_LOOKUP, 1'b0, 64'h1000, 64'd1, '0);
    push_req(REQ_FILL, 1'b1, '1, 64'd0, 32'h2);
    push_req(REQ_TICK, 1'b0, '0, '0, '0);
    wait_drained();

    write_reg(REG_EXPIRY, 32'd40);
    write_reg(REG_RMASK, $urandom);
    write_reg(REG_WMASK, $urandom);
    write_reg(REG_DMASK, $urandom & $urandom);
    gen_random(300);
    wait_drained();

    write_reg(REG_EXPIRY, 32'd0);
    write_reg(REG_RMASK, '1);
    write_reg(REG_WMASK, '0);
    write_reg(REG_DMASK, '0);
    gen_random(300);
    wait_drained();

    idle_mode = RECV_LIGHT;
    write_reg(REG_EXPIRY, '1);
    write_reg(REG_RMASK, '0);
    write_reg(REG_WMASK, '1);
    write_reg(REG_DMASK, '1);
    gen_random(300);
    wait_drained();

    write_reg(REG_EXPIRY, 32'd3);
    write_reg(REG_RMASK, $urandom);
    write_reg(REG_WMASK, $urandom);
    write_reg(REG_DMASK, $urandom & $urandom & $urandom);
    gen_random(300);
    wait_drained();

    idle_mode = NO_IDLE;
    write_reg(REG_EXPIRY, EXPIRY_RST);
    write_reg(REG_RMASK, RMASK_RST);
    write_reg(REG_WMASK, WMASK_RST);
    write_reg(REG_DMASK, DMASK_RST);
    gen_random(300);
    wait_drained();

    write_reg(REG_EXPIRY, 32'd200);
    write_reg(REG_RMASK, $urandom);
    write_reg(REG_WMASK, $urandom);
    write_reg(REG_DMASK, $urandom & 32'h0000_FF00);
    gen_random(300);
    wait_drained();

    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
